// ----- sv/bts_pkg.sv -----
// Shared types and constants for the bilinear texture sampler.
// No dependencies; imported by every module of the block.
package bts_pkg;

  localparam int unsigned CoordW    = 18;
  localparam int unsigned FracW     = 16;
  localparam int unsigned SideW     = 9;
  localparam int unsigned MaxSide   = 256;
  localparam int unsigned CornerW   = 8;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned TexDepth  = 1 << AddrW;
  localparam int unsigned TexelW    = 24;
  localparam int unsigned ScaledW   = FracW + CornerW;
  localparam int unsigned WeightW   = 2 * FracW + 1;
  localparam int unsigned ProdW     = 40;
  localparam int unsigned ChanOutW  = 16;
  localparam int unsigned OutShift  = 2 * FracW - 8;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1
  } bts_reg_e;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } bts_act_e;

  typedef struct packed {
    logic vld;
    logic smp;
    logic bad;
  } bts_ctl_t;

  typedef logic [AddrW-1:0]   bts_addr_t;
  typedef logic [WeightW-1:0] bts_wt_t;
  typedef logic [TexelW-1:0]  bts_texel_t;

endpackage

// ----- sv/bts_coord.sv -----
// Coordinate stages: range check, scale by size-1, corner addresses and weights.
// Depends on bts_pkg.
module bts_coord import bts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic                     action_i,
  input  logic [AddrW-1:0]         texel_index_i,
  input  bts_texel_t               rgb_i,
  input  logic signed [CoordW-1:0] coord_u_i,
  input  logic signed [CoordW-1:0] coord_v_i,
  input  logic [SideW-1:0]         width_i,
  input  logic [SideW-1:0]         height_i,
  output bts_ctl_t                 ctl_o,
  output bts_addr_t                addr_o [4],
  output bts_wt_t                  wt_o [4],
  output bts_addr_t                widx_o,
  output bts_texel_t               wrgb_o
);

  logic [SideW-1:0]   w_c, h_c;
  logic [CornerW-1:0] wm1, hm1;
  logic               u_bad, v_bad;
  logic [FracW:0]     u_mag, v_mag;

  always_comb begin
    w_c = width_i;
    if (width_i == '0) w_c = SideW'(1);
    else if (width_i > SideW'(MaxSide)) w_c = SideW'(MaxSide);
    h_c = height_i;
    if (height_i == '0) h_c = SideW'(1);
    else if (height_i > SideW'(MaxSide)) h_c = SideW'(MaxSide);
    wm1 = CornerW'(w_c - SideW'(1));
    hm1 = CornerW'(h_c - SideW'(1));
    u_mag = coord_u_i[FracW:0];
    v_mag = coord_v_i[FracW:0];
    u_bad = coord_u_i[CoordW-1] || (coord_u_i[CoordW-2:0] > (CoordW-1)'(1 << FracW));
    v_bad = coord_v_i[CoordW-1] || (coord_v_i[CoordW-2:0] > (CoordW-1)'(1 << FracW));
  end

  bts_ctl_t           ctl1_q;
  logic [ScaledW-1:0] su1_q, sv1_q;
  logic [SideW-1:0]   w1_q;
  bts_addr_t          widx1_q;
  bts_texel_t         wrgb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q.vld <= take_i;
      ctl1_q.smp <= action_i == ACT_SAMPLE;
      ctl1_q.bad <= u_bad || v_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    su1_q   <= ScaledW'(u_mag * wm1);
    sv1_q   <= ScaledW'(v_mag * hm1);
    w1_q    <= w_c;
    widx1_q <= texel_index_i;
    wrgb1_q <= rgb_i;
  end

  logic [CornerW-1:0] left, top;
  logic [FracW-1:0]   s, t;
  logic [CornerW-1:0] right, bottom;
  logic [FracW:0]     oms, omt;
  logic [AddrW:0]     row_top, row_bot;
  bts_addr_t          addr_d [4];
  bts_wt_t            wt_d [4];

  always_comb begin
    left    = su1_q[ScaledW-1:FracW];
    top     = sv1_q[ScaledW-1:FracW];
    s       = su1_q[FracW-1:0];
    t       = sv1_q[FracW-1:0];
    right   = CornerW'(left + CornerW'(s != '0));
    bottom  = CornerW'(top + CornerW'(t != '0));
    oms     = (FracW+1)'(1 << FracW) - (FracW+1)'(s);
    omt     = (FracW+1)'(1 << FracW) - (FracW+1)'(t);
    row_top = (AddrW+1)'(top * w1_q);
    row_bot = (AddrW+1)'(bottom * w1_q);
    addr_d[0] = AddrW'(row_top + (AddrW+1)'(left));
    addr_d[1] = AddrW'(row_top + (AddrW+1)'(right));
    addr_d[2] = AddrW'(row_bot + (AddrW+1)'(right));
    addr_d[3] = AddrW'(row_bot + (AddrW+1)'(left));
    wt_d[0] = WeightW'(oms * omt);
    wt_d[1] = WeightW'(s * omt);
    wt_d[2] = WeightW'(s * t);
    wt_d[3] = WeightW'(oms * t);
  end

  bts_ctl_t ctl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_o <= addr_d;
    wt_o   <= wt_d;
    widx_o <= widx1_q;
    wrgb_o <= wrgb1_q;
  end

  assign ctl_o = ctl2_q;

endmodule

// ----- sv/bts_texram.sv -----
// Texel store copy: one write port, two read ports with registered data.
// Depends on bts_pkg.
module bts_texram import bts_pkg::*; (
  input  logic       clk_i,
  input  logic       we_i,
  input  bts_addr_t  waddr_i,
  input  bts_texel_t wdata_i,
  input  bts_addr_t  raddr_a_i,
  input  bts_addr_t  raddr_b_i,
  output bts_texel_t rdata_a_o,
  output bts_texel_t rdata_b_o
);

  bts_texel_t mem_q [TexDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- sv/bts_blend.sv -----
// Blend stages: weight times channel products, then per-channel sum and scale.
// Depends on bts_pkg.
module bts_blend import bts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bts_ctl_t            ctl_i,
  input  bts_wt_t             wt_i [4],
  input  bts_texel_t          texel_i [4],
  output logic                valid_o,
  output logic [ChanOutW-1:0] red_o,
  output logic [ChanOutW-1:0] green_o,
  output logic [ChanOutW-1:0] blue_o,
  output logic                status_o
);

  bts_ctl_t         ctl4_q;
  logic [ProdW-1:0] prod_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[k][c] <= ProdW'(wt_i[c] * texel_i[c][TexelW-1-8*k -: 8]);
      end
    end
  end

  logic [ProdW-1:0]    sum [3];
  logic [ChanOutW-1:0] chan_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = prod_q[k][0] + prod_q[k][1] + prod_q[k][2] + prod_q[k][3];
      chan_d[k] = ctl4_q.bad ? '0 : sum[k][OutShift +: ChanOutW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= ctl4_q.vld && ctl4_q.smp;
    end
  end

  always_ff @(posedge clk_i) begin
    red_o    <= chan_d[0];
    green_o  <= chan_d[1];
    blue_o   <= chan_d[2];
    status_o <= ctl4_q.bad;
  end

endmodule

// ----- sv/bilinear_texture_sample.sv -----
// Bilinear texture sampler top level: config registers, pipeline, texel store.
// A sample reaches valid_o after its start transfer through the registered stages
// scale, corners and weights, texel read, weight products and channel sum.
// Throughput: one item per cycle; busy stays low, results cannot be stalled.
// Reset clears pipeline valid bits and sets width and height to 256.
// Depends on bts_pkg, bts_coord, bts_texram, bts_blend.
module bilinear_texture_sample import bts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [SideW-1:0]         cfg_data_i,
  input  logic                     action_i,
  input  logic [AddrW-1:0]         texel_index_i,
  input  logic [7:0]               red_in_i,
  input  logic [7:0]               green_in_i,
  input  logic [7:0]               blue_in_i,
  input  logic signed [CoordW-1:0] coord_u_i,
  input  logic signed [CoordW-1:0] coord_v_i,
  output logic                     valid_o,
  output logic [ChanOutW-1:0]      red_out_o,
  output logic [ChanOutW-1:0]      green_out_o,
  output logic [ChanOutW-1:0]      blue_out_o,
  output logic                     status_o
);

  logic [SideW-1:0] width_q, height_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(MaxSide);
      height_q <= SideW'(MaxSide);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TEX_WIDTH:  width_q  <= cfg_data_i;
        REG_TEX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bts_ctl_t   ctl2;
  bts_addr_t  addr2 [4];
  bts_wt_t    wt2 [4];
  bts_addr_t  widx2;
  bts_texel_t wrgb2;

  bts_coord u_coord (
    .clk_i,
    .rst_ni,
    .take_i        (start && !busy),
    .action_i,
    .texel_index_i,
    .rgb_i         ({red_in_i, green_in_i, blue_in_i}),
    .coord_u_i,
    .coord_v_i,
    .width_i       (width_q),
    .height_i      (height_q),
    .ctl_o         (ctl2),
    .addr_o        (addr2),
    .wt_o          (wt2),
    .widx_o        (widx2),
    .wrgb_o        (wrgb2)
  );

  logic       we;
  bts_texel_t texel3 [4];

  assign we = ctl2.vld && !ctl2.smp;

  bts_texram u_ram_ab (
    .clk_i,
    .we_i      (we),
    .waddr_i   (widx2),
    .wdata_i   (wrgb2),
    .raddr_a_i (addr2[0]),
    .raddr_b_i (addr2[1]),
    .rdata_a_o (texel3[0]),
    .rdata_b_o (texel3[1])
  );

  bts_texram u_ram_cd (
    .clk_i,
    .we_i      (we),
    .waddr_i   (widx2),
    .wdata_i   (wrgb2),
    .raddr_a_i (addr2[2]),
    .raddr_b_i (addr2[3]),
    .rdata_a_o (texel3[2]),
    .rdata_b_o (texel3[3])
  );

  bts_ctl_t ctl3_q;
  bts_wt_t  wt3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl2;
    end
  end

  always_ff @(posedge clk_i) begin
    wt3_q <= wt2;
  end

  bts_blend u_blend (
    .clk_i,
    .rst_ni,
    .ctl_i    (ctl3_q),
    .wt_i     (wt3_q),
    .texel_i  (texel3),
    .valid_o,
    .red_o    (red_out_o),
    .green_o  (green_out_o),
    .blue_o   (blue_out_o),
    .status_o
  );

endmodule

// ----- sv/bts_checker.sv -----
// Port-level checker for the bilinear texture sampler, bound to the top level.
// Depends on bts_pkg and bilinear_texture_sample.
module bts_checker import bts_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     action_i,
  input logic signed [CoordW-1:0] coord_u_i,
  input logic                     valid_o,
  input logic [ChanOutW-1:0]      red_out_o,
  input logic [ChanOutW-1:0]      green_out_o,
  input logic [ChanOutW-1:0]      blue_out_o,
  input logic                     status_o
);

  a_result_has_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy && action_i == ACT_SAMPLE, 5))
    else $error("result without a sample transfer");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> red_out_o == '0 && green_out_o == '0 && blue_out_o == '0)
    else $error("failed sample carries color");

  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> red_out_o <= 16'hFF00 && green_out_o <= 16'hFF00 && blue_out_o <= 16'hFF00)
    else $error("color above full scale");

  a_neg_u_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && action_i == ACT_SAMPLE && coord_u_i[CoordW-1] |-> ##5 valid_o && status_o)
    else $error("negative u not reported");

endmodule

bind bilinear_texture_sample bts_checker u_bts_checker (
  .clk_i,
  .rst_ni,
  .start,
  .busy,
  .action_i,
  .coord_u_i,
  .valid_o,
  .red_out_o,
  .green_out_o,
  .blue_out_o,
  .status_o
);
